FILE: hdl/nsr_pkg.sv
// Shared types and constants for the Newton square root block.
// Used by every module under hdl; depends on nothing.
package nsr_pkg;

    localparam int OPERAND_W          = 32;
    localparam int ROOT_W             = 24;
    localparam int STATUS_W           = 2;
    localparam int TOL_W              = 31;
    localparam int MAX_ITERATIONS_DEF = 32;
    localparam int FRACTION_BITS_DEF  = 16;

    localparam logic [ROOT_W-1:0] ROOT_MAX  = {ROOT_W{1'b1}};
    localparam logic [TOL_W-1:0]  TOL_RESET = TOL_W'(1);

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK  = 2'd0,
        STAT_NAN = 2'd1,
        STAT_CAP = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_DIV,
        S_STEP,
        S_DIFF,
        S_CHECK,
        S_DONE
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic div_start;
        logic div_step;
        logic est_update;
        logic diff_calc;
        logic advance;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic neg;
        logic trivial;
        logic div_done;
        logic converged;
    } flags_t;

endpackage

FILE: hdl/newton_square_root.sv
// Top level of the Newton square root block: tolerance register, output
// register and the controller/datapath pair. Uses nsr_pkg, nsr_ctrl, nsr_dp.
//
// Usage: one signed Q16.16 operand enters on in_valid/in_stall; one result
// (unsigned root, 24 bits, and a 2-bit status) leaves on out_valid/out_stall.
// An item is taken at a clock edge with valid high and stall low.
// The tolerance register is written with cfg_we/cfg_data; the user must write
// it only while idle, as the block itself does not enforce this. It resets to 1.
// Negative, zero and one operands go from accept straight to S_DONE. Other
// operands run Newton iterations (at most MAX_ITERATIONS); each iteration
// is a division by the radix-2 restoring divider, which retires one quotient
// bit per cycle over the 31+FRACTION_BITS bit dividend, followed by the
// S_STEP, S_DIFF and S_CHECK states. One item is in work at a time; in_stall
// is high from accept until the result enters the output register, so the
// next operand is not taken before the last one has its result stored.
// A finished result waits in the output register while out_stall is high,
// and the next operand can be accepted meanwhile.
// Reset clears the controller and the output valid, and sets the tolerance register to 1.
module newton_square_root #(
    parameter int MAX_ITERATIONS = nsr_pkg::MAX_ITERATIONS_DEF,
    parameter int FRACTION_BITS  = nsr_pkg::FRACTION_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [nsr_pkg::TOL_W-1:0]            cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic signed [nsr_pkg::OPERAND_W-1:0] operand,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [nsr_pkg::ROOT_W-1:0]           root,
    output logic [nsr_pkg::STATUS_W-1:0]         status
);

    logic [nsr_pkg::TOL_W-1:0]    tol_reg;
    logic                         valid_reg;
    logic [nsr_pkg::ROOT_W-1:0]   root_reg;
    logic [nsr_pkg::STATUS_W-1:0] status_reg;

    nsr_pkg::cmd_t    cmd;
    nsr_pkg::flags_t  flags;
    nsr_pkg::status_t res_status;
    logic [nsr_pkg::ROOT_W-1:0] root_sat;
    logic busy;
    logic out_free;
    logic out_load;

    assign out_free = !valid_reg || !out_stall;
    assign in_stall = busy;

    nsr_ctrl #(
        .MAX_ITERATIONS(MAX_ITERATIONS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .out_free  (out_free),
        .flags     (flags),
        .cmd       (cmd),
        .busy      (busy),
        .out_load  (out_load),
        .out_status(res_status)
    );

    nsr_dp #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .operand  (operand),
        .tolerance(tol_reg),
        .cmd      (cmd),
        .flags    (flags),
        .root_sat (root_sat)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg   <= nsr_pkg::TOL_RESET;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                tol_reg <= cfg_data;
            if (out_load)
                valid_reg <= 1'b1;
            else if (!out_stall)
                valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            // not a number gives a zero root
            root_reg   <= (res_status == nsr_pkg::STAT_NAN) ? '0 : root_sat;
            status_reg <= res_status;
        end
    end

    assign out_valid = valid_reg;
    assign root      = root_reg;
    assign status    = status_reg;

endmodule

FILE: hdl/nsr_dp.sv
// Datapath of the Newton square root: estimate registers, restoring
// divider, change measurement and root saturation. Uses nsr_pkg.
module nsr_dp #(
    parameter int FRACTION_BITS = nsr_pkg::FRACTION_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic signed [nsr_pkg::OPERAND_W-1:0] operand,
    input  logic [nsr_pkg::TOL_W-1:0]          tolerance,
    input  nsr_pkg::cmd_t                      cmd,
    output nsr_pkg::flags_t                    flags,
    output logic [nsr_pkg::ROOT_W-1:0]         root_sat
);

    localparam int NW = nsr_pkg::OPERAND_W - 1;
    localparam int QW = NW + FRACTION_BITS;
    localparam int CW = $clog2(QW + 1);

    logic [NW-1:0] n_reg;
    logic [QW-1:0] last_reg, last_next;
    logic [QW-1:0] est_reg, est_next;
    logic [QW-1:0] diff_reg, diff_next;
    logic [QW-1:0] dvd_reg, dvd_next;
    logic [QW-1:0] dsr_reg, dsr_next;
    logic [QW-1:0] rem_reg, rem_next;
    logic [CW-1:0] cnt_reg, cnt_next;

    logic [NW-1:0] n_in;
    logic [QW:0]   trial;
    logic          fits;
    logic [QW:0]   sum;

    assign n_in  = operand[NW-1:0];
    assign trial = {rem_reg, dvd_reg[QW-1]};
    assign fits  = trial >= {1'b0, dsr_reg};
    assign sum   = {1'b0, last_reg} + {1'b0, dvd_reg};

    always_comb
    begin
        flags.neg       = operand[nsr_pkg::OPERAND_W-1];
        flags.trivial   = (n_in == '0) || (n_in == (NW'(1) << FRACTION_BITS));
        flags.div_done  = (cnt_reg == '0);
        flags.converged = diff_reg <= QW'(tolerance);
    end

    always_comb
    begin
        last_next = last_reg;
        est_next  = est_reg;
        diff_next = diff_reg;
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        if (cmd.load)
        begin
            last_next = QW'(n_in);
            est_next  = QW'(n_in);
        end
        if (cmd.div_start)
        begin
            dvd_next = {n_reg, {FRACTION_BITS{1'b0}}};
            // guard: a zero divisor divides as one
            dsr_next = (last_reg == '0) ? QW'(1) : last_reg;
            rem_next = '0;
            cnt_next = CW'(QW);
        end
        if (cmd.div_step)
        begin
            rem_next = fits ? QW'(trial - {1'b0, dsr_reg}) : trial[QW-1:0];
            dvd_next = {dvd_reg[QW-2:0], fits};
            cnt_next = cnt_reg - CW'(1);
        end
        if (cmd.est_update)
            est_next = sum[QW:1];
        if (cmd.diff_calc)
            diff_next = (last_reg > est_reg) ? (last_reg - est_reg) : (est_reg - last_reg);
        if (cmd.advance)
            last_next = est_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            n_reg <= n_in;
        last_reg <= last_next;
        est_reg  <= est_next;
        diff_reg <= diff_next;
        dvd_reg  <= dvd_next;
        dsr_reg  <= dsr_next;
        rem_reg  <= rem_next;
    end

    assign root_sat = (est_reg > QW'(nsr_pkg::ROOT_MAX)) ? nsr_pkg::ROOT_MAX
                                                          : est_reg[nsr_pkg::ROOT_W-1:0];

endmodule

FILE: hdl/nsr_ctrl.sv
// Controller of the Newton square root: sequences division, update and
// convergence test, and counts iterations. Uses nsr_pkg.
module nsr_ctrl #(
    parameter int MAX_ITERATIONS = nsr_pkg::MAX_ITERATIONS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             out_free,
    input  nsr_pkg::flags_t  flags,
    output nsr_pkg::cmd_t    cmd,
    output logic             busy,
    output logic             out_load,
    output nsr_pkg::status_t out_status
);

    localparam int IW = $clog2(MAX_ITERATIONS + 1);

    nsr_pkg::state_t  state_reg, state_next;
    nsr_pkg::status_t stat_reg, stat_next;
    logic [IW-1:0]    iter_reg, iter_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= nsr_pkg::S_IDLE;
            stat_reg  <= nsr_pkg::STAT_OK;
            iter_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            stat_reg  <= stat_next;
            iter_reg  <= iter_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        stat_next  = stat_reg;
        iter_next  = iter_reg;
        cmd        = '0;
        out_load   = 1'b0;
        busy       = 1'b1;
        case (state_reg)
            nsr_pkg::S_IDLE:
            begin
                busy = 1'b0;
                if (in_valid)
                begin
                    cmd.load  = 1'b1;
                    iter_next = '0;
                    if (flags.neg)
                    begin
                        stat_next  = nsr_pkg::STAT_NAN;
                        state_next = nsr_pkg::S_DONE;
                    end
                    else if (flags.trivial)
                    begin
                        stat_next  = nsr_pkg::STAT_OK;
                        state_next = nsr_pkg::S_DONE;
                    end
                    else
                    begin
                        state_next = nsr_pkg::S_START;
                    end
                end
            end
            nsr_pkg::S_START:
            begin
                cmd.div_start = 1'b1;
                state_next    = nsr_pkg::S_DIV;
            end
            nsr_pkg::S_DIV:
            begin
                if (flags.div_done)
                    state_next = nsr_pkg::S_STEP;
                else
                    cmd.div_step = 1'b1;
            end
            nsr_pkg::S_STEP:
            begin
                cmd.est_update = 1'b1;
                iter_next      = iter_reg + IW'(1);
                state_next     = nsr_pkg::S_DIFF;
            end
            nsr_pkg::S_DIFF:
            begin
                cmd.diff_calc = 1'b1;
                state_next    = nsr_pkg::S_CHECK;
            end
            nsr_pkg::S_CHECK:
            begin
                if (flags.converged)
                begin
                    stat_next  = nsr_pkg::STAT_OK;
                    state_next = nsr_pkg::S_DONE;
                end
                else if (iter_reg >= IW'(MAX_ITERATIONS))
                begin
                    stat_next  = nsr_pkg::STAT_CAP;
                    state_next = nsr_pkg::S_DONE;
                end
                else
                begin
                    cmd.advance = 1'b1;
                    state_next  = nsr_pkg::S_START;
                end
            end
            nsr_pkg::S_DONE:
            begin
                // hold until the output register can take the item
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = nsr_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = nsr_pkg::S_IDLE;
            end
        endcase
    end

    assign out_status = stat_reg;

endmodule

FILE: hdl/nsr_checker.sv
// Port-level checks for newton_square_root, attached with bind.
// Uses nsr_pkg for the status codes.
module nsr_checker (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 in_valid,
    input logic                                 in_stall,
    input logic                                 out_valid,
    input logic                                 out_stall,
    input logic [nsr_pkg::ROOT_W-1:0]           root,
    input logic [nsr_pkg::STATUS_W-1:0]         status
);

    // one item at a time: an accept closes the input side
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input accepted while an item is in work");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(root) && $stable(status))
        else $error("stalled result changed");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == nsr_pkg::STAT_OK) || (status == nsr_pkg::STAT_NAN)
                      || (status == nsr_pkg::STAT_CAP))
        else $error("undefined status code");

    a_nan_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == nsr_pkg::STAT_NAN) |-> root == '0)
        else $error("not-a-number result with nonzero root");

endmodule

bind newton_square_root nsr_checker u_nsr_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .root     (root),
    .status   (status)
);
